// ===== design/gohi_pkg.sv =====
// ----------------------------------------------------------------------------
// gohi_pkg
// Shared types and constants of the gradient orientation integral histogram.
// ----------------------------------------------------------------------------
package gohi_pkg;

	localparam int MaxWidthDefault    = 512;
	localparam int MaxHeightDefault   = 512;
	localparam int BinCount           = 9;
	localparam int MagFracBitsDefault = 4;

	localparam int GradW  = 11;
	localparam int RowSumW = 24;
	localparam int IntegW = 33;
	localparam int BinIdxW = 4;

	localparam logic [RowSumW-1:0] RowSumMax = '1;
	localparam logic [IntegW-1:0]  IntegMax  = '1;

	// Q32 tangents of 10, 30, 50 and 70 degrees.
	localparam logic [33:0] Tan10 = 34'd757318616;
	localparam logic [33:0] Tan30 = 34'd2479700524;
	localparam logic [33:0] Tan50 = 34'd5118542705;
	localparam logic [33:0] Tan70 = 34'd11800325663;

	// One classified pixel handed from front to back.
	typedef struct packed {
		logic [BinIdxW-1:0] bin;
		logic [21:0]        sq;
		logic               row_end;
		logic               frame_end;
	} front_req_t;

	typedef logic [IntegW-1:0] integ_t;

endpackage

// ===== design/gohi_if.sv =====
// ----------------------------------------------------------------------------
// gohi_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface gohi_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/gohi_in_if.sv =====
// ----------------------------------------------------------------------------
// gohi_in_if
// Input pixel channel: Sobel gradient pair and row/frame marks.
// ----------------------------------------------------------------------------
interface gohi_in_if ();
	logic              valid;
	logic              ready;
	logic signed [10:0] grad_x;
	logic signed [10:0] grad_y;
	logic              row_end;
	logic              frame_end;

	modport source (output valid, grad_x, grad_y, row_end, frame_end, input ready);
	modport sink (input valid, grad_x, grad_y, row_end, frame_end, output ready);
endinterface

// ===== design/gohi_out_if.sv =====
// ----------------------------------------------------------------------------
// gohi_out_if
// Output channel: nine integral values and row/frame marks.
// ----------------------------------------------------------------------------
interface gohi_out_if ();
	logic        valid;
	logic        ready;
	logic [32:0] integral_bin0;
	logic [32:0] integral_bin1;
	logic [32:0] integral_bin2;
	logic [32:0] integral_bin3;
	logic [32:0] integral_bin4;
	logic [32:0] integral_bin5;
	logic [32:0] integral_bin6;
	logic [32:0] integral_bin7;
	logic [32:0] integral_bin8;
	logic        out_row_end;
	logic        out_frame_end;

	modport source (output valid, integral_bin0, integral_bin1, integral_bin2,
		integral_bin3, integral_bin4, integral_bin5, integral_bin6, integral_bin7,
		integral_bin8, out_row_end, out_frame_end, input ready);
	modport sink (input valid, integral_bin0, integral_bin1, integral_bin2,
		integral_bin3, integral_bin4, integral_bin5, integral_bin6, integral_bin7,
		integral_bin8, out_row_end, out_frame_end, output ready);
endinterface

// ===== design/gohi_front.sv =====
// ----------------------------------------------------------------------------
// gohi_front
// Classifies a pixel: squared magnitude and orientation bin, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module gohi_front (
	input  logic                    clk,
	input  logic                    arst_n,
	gohi_in_if.sink                 pix,
	gohi_if.source                  req
);
	import gohi_pkg::*;

	logic signed [11:0] ax;
	logic signed [11:0] ay;
	logic        [21:0] sq;
	logic signed [45:0] lhs;
	logic        [45:0] p10;
	logic        [45:0] p30;
	logic        [45:0] p50;
	logic        [45:0] p70;
	logic [BinIdxW-1:0] bin;
	front_req_t         req_q;
	logic               valid_q;

	// Fold gx to be non-negative; negate both when gx is negative.
	always_comb begin
		ax = (pix.grad_x < 0) ? -12'(pix.grad_x) : 12'(pix.grad_x);
		ay = (pix.grad_x < 0) ? -12'(pix.grad_y) : 12'(pix.grad_y);
		sq = 22'(pix.grad_x * pix.grad_x) + 22'(pix.grad_y * pix.grad_y);
		lhs = {{2{ay[11]}}, ay, 32'd0};
		p10 = 46'(Tan10 * 12'(ax));
		p30 = 46'(Tan30 * 12'(ax));
		p50 = 46'(Tan50 * 12'(ax));
		p70 = 46'(Tan70 * 12'(ax));
	end

	// Bin by comparison against the sector tangents.
	always_comb begin
		if (pix.grad_x == '0) begin
			if (pix.grad_y > 0) bin = 4'd8;
			else if (pix.grad_y < 0) bin = 4'd0;
			else bin = 4'd4;
		end else if (lhs <= -$signed(p70)) bin = 4'd0;
		else if (lhs <= -$signed(p50)) bin = 4'd1;
		else if (lhs <= -$signed(p30)) bin = 4'd2;
		else if (lhs <= -$signed(p10)) bin = 4'd3;
		else if (lhs <= $signed(p10)) bin = 4'd4;
		else if (lhs <= $signed(p30)) bin = 4'd5;
		else if (lhs <= $signed(p50)) bin = 4'd6;
		else if (lhs <= $signed(p70)) bin = 4'd7;
		else bin = 4'd8;
	end

	assign pix.ready = !valid_q || req.ready;
	assign req.valid = valid_q;
	assign req.data  = req_q;

	// Output register of the front part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pix.ready) begin
			valid_q <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			req_q.bin       <= bin;
			req_q.sq        <= sq;
			req_q.row_end   <= pix.row_end;
			req_q.frame_end <= pix.frame_end;
		end
	end

endmodule

// ===== design/gohi_fifo.sv =====
// ----------------------------------------------------------------------------
// gohi_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module gohi_fifo (
	input  logic    clk,
	input  logic    arst_n,
	gohi_if.sink    wr,
	gohi_if.source  rd
);
	import gohi_pkg::*;

	front_req_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr.ready = cnt_q != 2'd2;
	assign rd.valid = cnt_q != 2'd0;
	assign rd.data  = mem_q[rp_q];
	assign push = wr.valid && wr.ready;
	assign pop  = rd.valid && rd.ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr.data;
	end

endmodule

// ===== design/gohi_back.sv =====
// ----------------------------------------------------------------------------
// gohi_back
// Square root, row sums and integral update, one pixel per cycle in a pipe unless stalled.
// ----------------------------------------------------------------------------
module gohi_back #(
	parameter int MAX_WIDTH     = gohi_pkg::MaxWidthDefault,
	parameter int MAG_FRAC_BITS = gohi_pkg::MagFracBitsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	gohi_if.sink      req,
	gohi_out_if.source res
);
	import gohi_pkg::*;

	localparam int SqW   = 22 + 2 * MAG_FRAC_BITS;
	localparam int RootW = SqW / 2;
	localparam int Steps = RootW;
	localparam int ColW  = $clog2(MAX_WIDTH);
	localparam int MemW  = BinCount * IntegW;

	// Pipeline: one sqrt digit per stage, then memory read, then sum.
	logic              v_s  [Steps+1];
	logic [SqW-1:0]    rem_s[Steps+1];
	logic [RootW-1:0]  rt_s [Steps+1];
	front_req_t        d_s  [Steps+1];
	logic              stall;

	assign stall = res.valid && !res.ready;
	assign req.ready = !stall;

	assign v_s[0]   = req.valid;
	assign rem_s[0] = SqW'(req.data.sq) << (2 * MAG_FRAC_BITS);
	assign rt_s[0]  = '0;
	assign d_s[0]   = req.data;

	// Restoring square root stages, one result bit each.
	for (genvar i = 0; i < Steps; i++) begin : g_sqrt
		localparam int Sh = 2 * (Steps - 1 - i);
		logic [SqW+1:0]   trial;
		logic [SqW+1:0]   hi;
		logic [SqW-1:0]   rem_n;
		logic [RootW-1:0] rt_n;
		always_comb begin
			hi    = (SqW+2)'(rem_s[i] >> Sh);
			trial = (SqW+2)'({rt_s[i], 2'b01});
			if (hi >= trial) begin
				rem_n = rem_s[i] - SqW'(trial << Sh);
				rt_n  = {rt_s[i][RootW-2:0], 1'b1};
			end else begin
				rem_n = rem_s[i];
				rt_n  = {rt_s[i][RootW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (!stall) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (!stall) begin
				rem_s[i+1] <= rem_n;
				rt_s[i+1]  <= rt_n;
				d_s[i+1]   <= d_s[i];
			end
		end
	end

	// Column and row state.
	logic [ColW-1:0]    col_q;
	logic               first_q;
	logic [RowSumW-1:0] rsum_q [BinCount];
	logic [RowSumW-1:0] rsum_n [BinCount];
	logic               go;
	front_req_t         dl;

	assign go = v_s[Steps] && !stall;
	assign dl = d_s[Steps];

	always_comb begin
		for (int b = 0; b < BinCount; b++) begin
			logic [RowSumW:0] t;
			t = {1'b0, rsum_q[b]};
			if (dl.bin == BinIdxW'(b)) begin
				t = t + (RowSumW+1)'(rt_s[Steps]);
			end
			rsum_n[b] = t[RowSumW] ? RowSumMax : t[RowSumW-1:0];
		end
	end

	// Stage A: register row sums, read previous row entry.
	logic [MemW-1:0]    mem [MAX_WIDTH];
	logic [MemW-1:0]    rd_s1;
	logic [RowSumW-1:0] sum_s1 [BinCount];
	logic               v1_s1;
	logic               first_s1;
	logic               re_s1;
	logic               fe_s1;
	logic [ColW-1:0]    col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
			v1_s1   <= 1'b0;
			for (int b = 0; b < BinCount; b++) rsum_q[b] <= '0;
		end else if (!stall) begin
			v1_s1 <= go;
			if (go) begin
				if (dl.row_end || dl.frame_end) begin
					col_q   <= '0;
					first_q <= dl.frame_end;
					for (int b = 0; b < BinCount; b++) rsum_q[b] <= '0;
				end else begin
					if (col_q != ColW'(MAX_WIDTH - 1)) col_q <= col_q + 1'b1;
					for (int b = 0; b < BinCount; b++) rsum_q[b] <= rsum_n[b];
				end
			end
		end
	end

	// Forward a write to the same column just completed (rows of length one).
	logic [MemW-1:0] wr_data;
	logic            wr_en;
	logic [ColW-1:0] wr_col;
	logic [ColW:0]   fill_q;

	// Columns are written from zero upward, so the written entries form a
	// prefix; entries at or beyond the fill mark read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr_en && {1'b0, wr_col} >= fill_q) begin
			fill_q <= {1'b0, wr_col} + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && go) begin
			rd_s1 <= (wr_en && wr_col == col_q) ? wr_data :
				(({1'b0, col_q} < fill_q) ? mem[col_q] : '0);
			for (int b = 0; b < BinCount; b++) sum_s1[b] <= rsum_n[b];
			first_s1 <= first_q;
			re_s1    <= dl.row_end;
			fe_s1    <= dl.frame_end;
			col_s1   <= col_q;
		end
	end

	// Stage B: add the entry above, saturate, write back and present.
	integ_t sat [BinCount];
	always_comb begin
		for (int b = 0; b < BinCount; b++) begin
			logic [IntegW:0] t;
			t = (IntegW+1)'(sum_s1[b]);
			if (!first_s1) t = t + (IntegW+1)'(rd_s1[b*IntegW +: IntegW]);
			sat[b] = t[IntegW] ? IntegMax : t[IntegW-1:0];
		end
		for (int b = 0; b < BinCount; b++) wr_data[b*IntegW +: IntegW] = sat[b];
	end
	assign wr_en  = v1_s1 && !stall;
	assign wr_col = col_s1;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_col] <= wr_data;
	end

	integ_t out_q [BinCount];
	logic   ov_q;
	logic   ore_q;
	logic   ofe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (!stall) begin
			ov_q <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int b = 0; b < BinCount; b++) out_q[b] <= sat[b];
			ore_q <= re_s1;
			ofe_q <= fe_s1;
		end
	end

	assign res.valid         = ov_q;
	assign res.integral_bin0 = out_q[0];
	assign res.integral_bin1 = out_q[1];
	assign res.integral_bin2 = out_q[2];
	assign res.integral_bin3 = out_q[3];
	assign res.integral_bin4 = out_q[4];
	assign res.integral_bin5 = out_q[5];
	assign res.integral_bin6 = out_q[6];
	assign res.integral_bin7 = out_q[7];
	assign res.integral_bin8 = out_q[8];
	assign res.out_row_end   = ore_q;
	assign res.out_frame_end = ofe_q;

endmodule

// ===== design/gradient_orientation_integral_histogram.sv =====
// ----------------------------------------------------------------------------
// gradient_orientation_integral_histogram
// Stages: classify, queue, one square root bit per stage, row memory read,
// integral add and output register.
// Throughput: one pixel per cycle while res is ready, with one row memory read and one write.
// Reset clears all control state; previous-row memory reads as zero on the
// first row of each frame and past the columns written since reset, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module gradient_orientation_integral_histogram #(
	parameter int MAX_WIDTH     = gohi_pkg::MaxWidthDefault,
	parameter int MAG_FRAC_BITS = gohi_pkg::MagFracBitsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	gohi_in_if.sink    pix,
	gohi_out_if.source res
);
	import gohi_pkg::*;

	gohi_if #(.payload_t(front_req_t)) f2q ();
	gohi_if #(.payload_t(front_req_t)) q2b ();

	// Front part: classification.
	gohi_front u_front (.clk(clk), .arst_n(arst_n), .pix(pix), .req(f2q.source));

	// Decoupling queue.
	gohi_fifo u_fifo (.clk(clk), .arst_n(arst_n), .wr(f2q.sink), .rd(q2b.source));

	// Back part: accumulation.
	gohi_back #(.MAX_WIDTH(MAX_WIDTH), .MAG_FRAC_BITS(MAG_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .req(q2b.sink), .res(res));

endmodule
